/* rtl/mezs_pkg.sv */
// ----------------------------------------------------------------------------
// mezs_pkg: shared types and constants of the motion envelope zoom smoother
// Holds the sequencer states, register indexes, fixed-point constants and
// small helper functions used by the datapath.
// ----------------------------------------------------------------------------
package mezs_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQZ,
		ST_ROOT,
		ST_DIV,
		ST_FMUL,
		ST_FUPD,
		ST_SM1,
		ST_SM2,
		ST_SM3,
		ST_BMUL,
		ST_GOAL,
		ST_ZMUL,
		ST_ZUPD,
		ST_DONE
	} mezs_state_t;

	typedef enum logic [2:0] {
		REG_ZOOM_DEFAULT  = 3'd0,
		REG_ZOOM_LOWER    = 3'd1,
		REG_ZOOM_UPPER    = 3'd2,
		REG_ZOOM_MOTION   = 3'd3,
		REG_SMOOTH_GAIN   = 3'd4,
		REG_FULL_SCALE    = 3'd5
	} mezs_reg_t;

	localparam logic [15:0] RISE_Q15        = 16'd13107;
	localparam logic [15:0] FALL_Q15        = 16'd3277;
	localparam logic [15:0] ONE_Q15         = 16'd32768;
	localparam logic [15:0] LEVEL_FLOOR     = 16'd33;
	localparam logic [15:0] SNAP_UNITS      = 16'd8;
	localparam logic [16:0] DEADBAND_UNITS  = 17'd32;
	localparam logic [16:0] SMOOTH_THREE    = 17'd98304;
	localparam logic [4:0]  ITER_LAST       = 5'd30;

	localparam logic [15:0] RST_ZOOM_DEFAULT = 16'd4096;
	localparam logic [15:0] RST_ZOOM_LOWER   = 16'd2048;
	localparam logic [15:0] RST_ZOOM_UPPER   = 16'd8192;
	localparam logic [15:0] RST_ZOOM_MOTION  = 16'd3277;
	localparam logic [15:0] RST_SMOOTH_GAIN  = 16'd4915;
	localparam logic [15:0] RST_FULL_SCALE   = 16'd2880;

	// magnitude minus deadband, never negative
	function automatic logic [14:0] dead_axis(input logic [15:0] raw);
		logic [16:0] mag;
		logic [16:0] d;
		mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
		d = (mag < DEADBAND_UNITS) ? 17'd0 : (mag - DEADBAND_UNITS);
		return d[14:0];
	endfunction

	// when the limits cross, values below the lower limit give it and all others the upper
	function automatic logic [15:0] limit_zoom(input logic [15:0] z,
			input logic [15:0] lo, input logic [15:0] hi);
		if (z < lo)
			return lo;
		else if (z > hi)
			return hi;
		return z;
	endfunction

	// round a Q15 product back to an integer step
	function automatic logic [15:0] round_step(input logic [47:0] p);
		logic [47:0] r;
		r = p + 48'd16384;
		return r[30:15];
	endfunction

endpackage

/* rtl/mezs_in_if.sv */
// ----------------------------------------------------------------------------
// mezs_in_if: gyro sample channel
// Valid/ready channel carrying one three-axis sample per transfer.
// ----------------------------------------------------------------------------
interface mezs_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic               sample_present;

	modport source (output valid, gyro_x, gyro_y, gyro_z, sample_present, input ready);
	modport sink   (input valid, gyro_x, gyro_y, gyro_z, sample_present, output ready);
endinterface

/* rtl/mezs_out_if.sv */
// ----------------------------------------------------------------------------
// mezs_out_if: zoom result channel
// Valid/ready channel carrying one zoom result per transfer.
// ----------------------------------------------------------------------------
interface mezs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] zoom_now;
	logic [15:0] zoom_goal;
	logic [15:0] motion_level;

	modport source (output valid, zoom_now, zoom_goal, motion_level, input ready);
	modport sink   (input valid, zoom_now, zoom_goal, motion_level, output ready);
endinterface

/* rtl/motion_envelope_zoom_smoother.sv */
// ----------------------------------------------------------------------------
// motion_envelope_zoom_smoother: gyro driven zoom envelope follower
// Turns gyro samples into an activity level, follows it with an asymmetric
// attack/release envelope and steers a smoothed zoom toward a blended target.
// ----------------------------------------------------------------------------
// Usage:
//   gyro  - sink channel, one sample per transfer. sample_present low means
//           zero activity for that tick.
//   zoom  - source channel, one result (zoom_now, zoom_goal, motion_level)
//           per accepted sample, in order.
//   wr_en / wr_index / wr_data - register writes, taken on any edge with
//           wr_en high; unknown indexes are ignored. Write only while idle.
// Sequence:
//   A present sample passes through the squares, the square root, the
//   divide and the envelope, blend and zoom steps (the zoom update is
//   skipped when the zoom already sits on its target), all through one
//   shared 32x17 multiplier. An absent sample skips to the envelope.
//   gyro.ready is high only in the idle state, so the next transfer waits
//   until the sequencer is back in idle.
// Reset:
//   arst_n clears the sequencer and the output valid, loads the register
//   defaults, zeroes the motion level and sets the zoom to 4096.
// Stall:
//   A finished result sits in the output register; the next sample is
//   accepted meanwhile and its result holds in the last state until the
//   output register frees up.
// ----------------------------------------------------------------------------
module motion_envelope_zoom_smoother
	import mezs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	mezs_in_if.sink            gyro,
	mezs_out_if.source         zoom,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data
);

	mezs_state_t state_q, state_d;

	// configuration
	logic [15:0] zoom_default_q, zoom_lower_q, zoom_upper_q, zoom_motion_q;
	logic [15:0] smooth_gain_q, full_scale_q;

	// tracked state
	logic [15:0] level_q;
	logic [15:0] zoom_cur_q;

	// working registers
	logic [14:0] gx_q, gy_q, gz_q;
	logic [31:0] sum_q;
	logic [61:0] rad_q;
	logic [30:0] root_q;
	logic [32:0] rem_q;
	logic [4:0]  cnt_q;
	logic [15:0] act_q;
	logic [47:0] prod_q;
	logic [15:0] sm_q;
	logic [15:0] goal_q;
	logic        up_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_now_q, out_goal_q, out_level_q;

	// shared multiplier
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] mul_p;
	assign mul_p = 49'(mul_a) * 49'(mul_b);

	logic        accept;
	logic        out_free;
	assign accept   = gyro.valid && gyro.ready;
	assign out_free = !out_valid_q || zoom.ready;

	// square root step: two radicand bits per cycle
	logic [34:0] sq_trial, sq_test;
	assign sq_trial = {rem_q, rad_q[61:60]};
	assign sq_test  = {2'b00, root_q, 2'b01};

	// restoring divide step: one quotient bit per cycle
	logic [16:0] dv_trial;
	logic [15:0] dv_den;
	assign dv_trial = {rem_q[15:0], root_q[30]};
	assign dv_den   = (full_scale_q == 16'd0) ? 16'd1 : full_scale_q;

	// envelope, blend and zoom operands
	logic        act_up;
	logic [15:0] act_gap;
	logic        def_down;
	logic [15:0] def_gap;
	logic        zoom_up;
	logic [15:0] zoom_gap;
	logic [15:0] gain_sat;
	assign act_up   = act_q > level_q;
	assign act_gap  = act_up ? (act_q - level_q) : (level_q - act_q);
	assign def_down = zoom_default_q >= zoom_motion_q;
	assign def_gap  = def_down ? (zoom_default_q - zoom_motion_q)
		: (zoom_motion_q - zoom_default_q);
	assign zoom_up  = goal_q > zoom_cur_q;
	assign zoom_gap = zoom_up ? (goal_q - zoom_cur_q) : (zoom_cur_q - goal_q);
	assign gain_sat = (smooth_gain_q > ONE_Q15) ? ONE_Q15 : smooth_gain_q;

	logic [15:0] step;
	assign step = round_step(prod_q);

	logic [15:0] lvl_next;
	assign lvl_next = up_q ? (level_q + step) : (level_q - step);

	logic [15:0] goal_raw;
	assign goal_raw = up_q ? (zoom_default_q - step) : (zoom_default_q + step);

	logic [15:0] nz, rest;
	assign nz   = up_q ? (zoom_cur_q + step) : (zoom_cur_q - step);
	assign rest = up_q ? (goal_q - nz) : (nz - goal_q);

	logic [47:0] sm_round;
	assign sm_round = prod_q + 48'h2000_0000;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = gyro.sample_present ? ST_SQX : ST_FMUL;
			end
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_SQZ;
			ST_SQZ:  state_d = ST_ROOT;
			ST_ROOT: if (cnt_q == ITER_LAST) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == ITER_LAST) state_d = ST_FMUL;
			ST_FMUL: state_d = ST_FUPD;
			ST_FUPD: state_d = ST_SM1;
			ST_SM1:  state_d = ST_SM2;
			ST_SM2:  state_d = ST_SM3;
			ST_SM3:  state_d = ST_BMUL;
			ST_BMUL: state_d = ST_GOAL;
			ST_GOAL: state_d = ST_ZMUL;
			ST_ZMUL: state_d = (zoom_cur_q == goal_q) ? ST_DONE : ST_ZUPD;
			ST_ZUPD: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and multiplier operand select
	always_comb begin
		gyro.ready = (state_q == ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQX: begin
				mul_a = 32'(gx_q);
				mul_b = 17'(gx_q);
			end
			ST_SQY: begin
				mul_a = 32'(gy_q);
				mul_b = 17'(gy_q);
			end
			ST_SQZ: begin
				mul_a = 32'(gz_q);
				mul_b = 17'(gz_q);
			end
			ST_FMUL: begin
				mul_a = 32'(act_gap);
				mul_b = act_up ? 17'(RISE_Q15) : 17'(FALL_Q15);
			end
			ST_SM1: begin
				mul_a = 32'(level_q);
				mul_b = 17'(level_q);
			end
			ST_SM2: begin
				mul_a = prod_q[31:0];
				mul_b = SMOOTH_THREE - {level_q, 1'b0};
			end
			ST_BMUL: begin
				mul_a = 32'(sm_q);
				mul_b = 17'(def_gap);
			end
			ST_ZMUL: begin
				mul_a = 32'(gain_sat);
				mul_b = 17'(zoom_gap);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign zoom.valid        = out_valid_q;
	assign zoom.zoom_now     = out_now_q;
	assign zoom.zoom_goal    = out_goal_q;
	assign zoom.motion_level = out_level_q;

	// control and tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			cnt_q          <= '0;
			level_q        <= '0;
			zoom_cur_q     <= RST_ZOOM_DEFAULT;
			zoom_default_q <= RST_ZOOM_DEFAULT;
			zoom_lower_q   <= RST_ZOOM_LOWER;
			zoom_upper_q   <= RST_ZOOM_UPPER;
			zoom_motion_q  <= RST_ZOOM_MOTION;
			smooth_gain_q  <= RST_SMOOTH_GAIN;
			full_scale_q   <= RST_FULL_SCALE;
		end else begin
			state_q <= state_d;

			if (wr_en) begin
				unique case (wr_index)
					REG_ZOOM_DEFAULT: zoom_default_q <= wr_data;
					REG_ZOOM_LOWER:   zoom_lower_q   <= wr_data;
					REG_ZOOM_UPPER:   zoom_upper_q   <= wr_data;
					REG_ZOOM_MOTION:  zoom_motion_q  <= wr_data;
					REG_SMOOTH_GAIN:  smooth_gain_q  <= wr_data;
					REG_FULL_SCALE:   full_scale_q   <= wr_data;
					default: ;
				endcase
			end

			// iteration counter for root and divide
			if (state_q == ST_ROOT || state_q == ST_DIV)
				cnt_q <= (cnt_q == ITER_LAST) ? 5'd0 : cnt_q + 5'd1;
			else
				cnt_q <= '0;

			if (state_q == ST_FUPD)
				level_q <= (lvl_next < LEVEL_FLOOR) ? 16'd0 : lvl_next;

			if (state_q == ST_ZUPD)
				zoom_cur_q <= (rest <= SNAP_UNITS) ? goal_q
					: limit_zoom(nz, zoom_lower_q, zoom_upper_q);

			// a new result wins over the transfer of the old one
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (zoom.valid && zoom.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				gx_q  <= dead_axis(gyro.gyro_x);
				gy_q  <= dead_axis(gyro.gyro_y);
				gz_q  <= dead_axis(gyro.gyro_z);
				act_q <= '0;
			end
			ST_SQX: sum_q <= mul_p[31:0];
			ST_SQY: sum_q <= sum_q + mul_p[31:0];
			ST_SQZ: begin
				sum_q  <= sum_q + mul_p[31:0];
				rad_q  <= {sum_q + mul_p[31:0], 30'd0};
				root_q <= '0;
				rem_q  <= '0;
			end
			ST_ROOT: begin
				rad_q <= {rad_q[59:0], 2'b00};
				if (sq_trial >= sq_test)
					root_q <= {root_q[29:0], 1'b1};
				else
					root_q <= {root_q[29:0], 1'b0};
				// clear the remainder for the divide after the last step
				if (cnt_q == ITER_LAST)
					rem_q <= '0;
				else if (sq_trial >= sq_test)
					rem_q <= 33'(sq_trial - sq_test);
				else
					rem_q <= sq_trial[32:0];
			end
			ST_DIV: begin
				if (dv_trial >= {1'b0, dv_den}) begin
					rem_q  <= 33'(dv_trial - {1'b0, dv_den});
					root_q <= {root_q[29:0], 1'b1};
				end else begin
					rem_q  <= 33'(dv_trial);
					root_q <= {root_q[29:0], 1'b0};
				end
				if (cnt_q == ITER_LAST) begin
					// root_q shifts in the last quotient bit here
					if ({root_q[29:0], dv_trial >= {1'b0, dv_den}} > 31'(ONE_Q15))
						act_q <= ONE_Q15;
					else
						act_q <= {root_q[14:0], dv_trial >= {1'b0, dv_den}};
				end
			end
			ST_FMUL: begin
				prod_q <= mul_p[47:0];
				up_q   <= act_up;
			end
			ST_SM1: prod_q <= mul_p[47:0];
			ST_SM2: prod_q <= mul_p[47:0];
			ST_SM3: sm_q   <= sm_round[45:30];
			ST_BMUL: begin
				prod_q <= mul_p[47:0];
				up_q   <= def_down;
			end
			ST_GOAL: goal_q <= limit_zoom(goal_raw, zoom_lower_q, zoom_upper_q);
			ST_ZMUL: begin
				prod_q <= mul_p[47:0];
				up_q   <= zoom_up;
			end
			ST_DONE: begin
				if (out_free) begin
					out_now_q   <= zoom_cur_q;
					out_goal_q  <= goal_q;
					out_level_q <= level_q;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after a sample transfer");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= ONE_Q15)
		else $error("motion level above one");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT || state_q == ST_DIV) |-> cnt_q <= ITER_LAST)
		else $error("iteration counter out of range");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output register was full");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not posted on leaving the last state");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for motion_envelope_zoom_smoother
// Drives gyro samples through the valid/ready input channel over several
// register settings and compares every zoom result field by field with an
// in-bench fixed-point model of the envelope follower and zoom smoother.
// ----------------------------------------------------------------------------
module testbench;
	import mezs_pkg::*;

	// indexes past the register file: writes to them must change nothing
	localparam logic [2:0] REG_UNMAPPED     = 3'd6;
	localparam logic [2:0] REG_UNMAPPED_TOP = 3'd7;
	localparam int         RANDOM_PER_PHASE = 115;
	localparam int         STALL_LIMIT      = 5000;
	localparam int         DRAIN_CYCLES     = 100;
	localparam int         LONG_HOLD        = 400;

	typedef struct packed {
		logic [15:0] zoom_now;
		logic [15:0] zoom_goal;
		logic [15:0] motion_level;
	} zoom_result_t;

	typedef struct {
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
		logic               present;
		bit                 typed;
		zoom_result_t       result;
	} sample_row_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	mezs_in_if  gyro_ch();
	mezs_out_if zoom_ch();

	motion_envelope_zoom_smoother u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.gyro     (gyro_ch),
		.zoom     (zoom_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// shadow copy of the register file and of the block's two state words
	logic [15:0]  shadow_reg [6];
	logic [15:0]  level_state;
	logic [15:0]  zoom_state;
	zoom_result_t zoom_expect_q [$];

	int  mismatches = 0;
	int  samples_sent = 0;
	int  results_seen = 0;
	bit  idle_enabled = 1'b1;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Fixed-point predictor
	// ------------------------------------------------------------------------
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bit_w;
		root = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= root + bit_w) begin
				v = v - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] axis_past_deadband(input logic signed [15:0] g);
		logic [16:0] mag;
		mag = g[15] ? (17'h10000 - {1'b0, g}) : {1'b0, g};
		return (mag < 17'd32) ? 64'd0 : 64'(mag - 17'd32);
	endfunction

	function automatic logic [31:0] gap_step(input logic [31:0] k, input logic [31:0] gap);
		logic [63:0] p;
		p = 64'(k) * 64'(gap) + 64'd16384;
		return 32'(p >> 15);
	endfunction

	function automatic logic [31:0] bound_zoom(input logic [31:0] z);
		if (z < 32'(shadow_reg[REG_ZOOM_LOWER]))
			return 32'(shadow_reg[REG_ZOOM_LOWER]);
		if (z > 32'(shadow_reg[REG_ZOOM_UPPER]))
			return 32'(shadow_reg[REG_ZOOM_UPPER]);
		return z;
	endfunction

	// advance the shadow state by one sample and return the result it gives
	function automatic zoom_result_t advance_zoom(input logic signed [15:0] gx,
			input logic signed [15:0] gy, input logic signed [15:0] gz, input logic present);
		logic [63:0] ax, ay, az, sum_sq, root, fs, quot, t, smooth, span;
		logic [31:0] activity, level, goal, dflt, motion, gain, cur, nz, rest;
		zoom_result_t r;
		activity = 0;
		if (present) begin
			ax = axis_past_deadband(gx);
			ay = axis_past_deadband(gy);
			az = axis_past_deadband(gz);
			sum_sq = ax * ax + ay * ay + az * az;
			root = int_sqrt(sum_sq << 30);
			fs = (shadow_reg[REG_FULL_SCALE] == 0) ? 64'd1 : 64'(shadow_reg[REG_FULL_SCALE]);
			quot = root / fs;
			activity = (quot > 64'd32768) ? 32'd32768 : 32'(quot);
		end

		// attack fast, release slow, floor tiny levels
		level = 32'(level_state);
		if (activity > level)
			level = level + gap_step(32'(RISE_Q15), activity - level);
		else
			level = level - gap_step(32'(FALL_Q15), level - activity);
		if (level < 32'(LEVEL_FLOOR))
			level = 0;

		t = 64'(level);
		smooth = (t * t * (64'd98304 - 2 * t) + (64'd1 << 29)) >> 30;

		dflt = 32'(shadow_reg[REG_ZOOM_DEFAULT]);
		motion = 32'(shadow_reg[REG_ZOOM_MOTION]);
		if (dflt >= motion) begin
			span = 64'(dflt - motion);
			goal = dflt - 32'((smooth * span + 64'd16384) >> 15);
		end else begin
			span = 64'(motion - dflt);
			goal = dflt + 32'((smooth * span + 64'd16384) >> 15);
		end
		goal = bound_zoom(goal);

		// an equal zoom is kept as is, even outside the limits
		cur = 32'(zoom_state);
		if (cur != goal) begin
			gain = (shadow_reg[REG_SMOOTH_GAIN] > 16'd32768) ? 32'd32768
				: 32'(shadow_reg[REG_SMOOTH_GAIN]);
			if (goal > cur) begin
				nz = cur + gap_step(gain, goal - cur);
				rest = goal - nz;
			end else begin
				nz = cur - gap_step(gain, cur - goal);
				rest = nz - goal;
			end
			cur = (rest <= 32'(SNAP_UNITS)) ? goal : bound_zoom(nz);
		end

		level_state = level[15:0];
		zoom_state = cur[15:0];
		r.zoom_now = cur[15:0];
		r.zoom_goal = goal[15:0];
		r.motion_level = level[15:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Register writes, only while the block is idle
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		if (idx <= REG_FULL_SCALE)
			shadow_reg[idx] = value;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		while (zoom_expect_q.size() != 0)
			@(posedge clk);
		// results are one per sample, so this only covers the last pipeline tail
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Sample driver: one transfer per call, expectation pushed on acceptance
	// ------------------------------------------------------------------------
	task automatic send_sample(input sample_row_t row);
		zoom_result_t predicted;
		if (idle_enabled && $urandom_range(0, 99) < 8) begin
			gyro_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		gyro_ch.valid <= 1'b1;
		gyro_ch.gyro_x <= row.gx;
		gyro_ch.gyro_y <= row.gy;
		gyro_ch.gyro_z <= row.gz;
		gyro_ch.sample_present <= row.present;
		@(posedge clk);
		while (!gyro_ch.ready)
			@(posedge clk);
		predicted = advance_zoom(row.gx, row.gy, row.gz, row.present);
		zoom_expect_q.push_back(row.typed ? row.result : predicted);
		samples_sent++;
	endtask

	function automatic logic signed [15:0] pick_axis();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 15)
			return 16'(signed'($urandom_range(0, 80)) - 40);
		if (sel < 25) begin
			case ($urandom_range(0, 3))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh0000;
				default: return 16'shFFFF;
			endcase
		end
		if (sel < 65)
			return 16'(signed'($urandom_range(0, 6000)) - 3000);
		return 16'($urandom);
	endfunction

	task automatic send_random(input int count);
		sample_row_t row;
		for (int i = 0; i < count; i++) begin
			row.gx = pick_axis();
			row.gy = pick_axis();
			row.gz = pick_axis();
			row.present = ($urandom_range(0, 99) >= 10);
			row.typed = 1'b0;
			row.result = '0;
			send_sample(row);
		end
	endtask

	// ------------------------------------------------------------------------
	// Directed rows; the first few start from reset and are typed in by hand
	// ------------------------------------------------------------------------
	sample_row_t directed_rows [] = '{
		// absent sample straight after reset: everything at rest
		'{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{16'd4096, 16'd4096, 16'd0}},
		// just inside the deadband on every axis
		'{16'sd31, -16'sd31, 16'sd0, 1'b1, 1'b1, '{16'd4096, 16'd4096, 16'd0}},
		// on the deadband edge: still zero activity
		'{-16'sd32, 16'sd32, -16'sd32, 1'b1, 1'b1, '{16'd4096, 16'd4096, 16'd0}},
		// present flag low with full-scale rates: ignored
		'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b1, '{16'd4096, 16'd4096, 16'd0}},
		'{16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0, '0},
		'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, '0},
		'{16'sh7FFF, 16'sh8000, 16'sd0, 1'b1, 1'b0, '0},
		'{16'sd33, 16'sd0, 16'sd0, 1'b1, 1'b0, '0},
		'{16'sd2912, 16'sd0, 16'sd0, 1'b1, 1'b0, '0},
		'{16'sd0, -16'sd2912, 16'sd0, 1'b1, 1'b0, '0},
		'{16'sd0, 16'sd0, 16'sd1000, 1'b1, 1'b0, '0},
		'{16'sh5555, 16'shAAAA, 16'sh00FF, 1'b1, 1'b0, '0},
		'{16'shAAAA, 16'sh5555, 16'shFF00, 1'b1, 1'b0, '0},
		// release back toward rest, through the level floor
		'{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
		'{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
		'{16'sd10, 16'sd10, 16'sd10, 1'b1, 1'b0, '0},
		'{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
		'{16'sd40, -16'sd40, 16'sd40, 1'b1, 1'b0, '0},
		'{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0}
	};

	// ------------------------------------------------------------------------
	// Stimulus sequence: reset, directed rows, then random phases over settings
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		gyro_ch.valid = 1'b0;
		gyro_ch.gyro_x = '0;
		gyro_ch.gyro_y = '0;
		gyro_ch.gyro_z = '0;
		gyro_ch.sample_present = 1'b0;
		shadow_reg[REG_ZOOM_DEFAULT] = RST_ZOOM_DEFAULT;
		shadow_reg[REG_ZOOM_LOWER] = RST_ZOOM_LOWER;
		shadow_reg[REG_ZOOM_UPPER] = RST_ZOOM_UPPER;
		shadow_reg[REG_ZOOM_MOTION] = RST_ZOOM_MOTION;
		shadow_reg[REG_SMOOTH_GAIN] = RST_SMOOTH_GAIN;
		shadow_reg[REG_FULL_SCALE] = RST_FULL_SCALE;
		level_state = '0;
		zoom_state = RST_ZOOM_DEFAULT;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sample(directed_rows[i]);
		send_random(RANDOM_PER_PHASE);

		// full scale of zero acts as one; gain above one saturates; unmapped index dropped
		gyro_ch.valid <= 1'b0;
		wait_drained();
		write_reg(REG_FULL_SCALE, 16'd0);
		write_reg(REG_SMOOTH_GAIN, 16'd40000);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		write_reg(REG_UNMAPPED_TOP, 16'h1234);
		send_random(RANDOM_PER_PHASE);

		// crossed limits: below lower gives lower, else upper; default above motion blends downward
		gyro_ch.valid <= 1'b0;
		wait_drained();
		write_reg(REG_ZOOM_LOWER, 16'd30000);
		write_reg(REG_ZOOM_UPPER, 16'd1000);
		write_reg(REG_ZOOM_DEFAULT, 16'hFFFF);
		write_reg(REG_ZOOM_MOTION, 16'd0);
		write_reg(REG_SMOOTH_GAIN, 16'd16384);
		write_reg(REG_FULL_SCALE, 16'd2880);
		send_random(RANDOM_PER_PHASE);

		// widest limits, zero gain, largest full scale
		gyro_ch.valid <= 1'b0;
		wait_drained();
		write_reg(REG_ZOOM_LOWER, 16'd0);
		write_reg(REG_ZOOM_UPPER, 16'hFFFF);
		write_reg(REG_ZOOM_DEFAULT, 16'd0);
		write_reg(REG_ZOOM_MOTION, 16'hFFFF);
		write_reg(REG_SMOOTH_GAIN, 16'd0);
		write_reg(REG_FULL_SCALE, 16'hFFFF);
		send_random(RANDOM_PER_PHASE / 2);
		// hold the sender until the block has handed back every result
		gyro_ch.valid <= 1'b0;
		while (zoom_expect_q.size() != 0)
			@(posedge clk);
		send_random(RANDOM_PER_PHASE / 2);

		// full gain, smallest full scale; rewriting the default leaves the zoom alone
		gyro_ch.valid <= 1'b0;
		wait_drained();
		write_reg(REG_SMOOTH_GAIN, 16'd32768);
		write_reg(REG_FULL_SCALE, 16'd1);
		write_reg(REG_ZOOM_DEFAULT, 16'd5000);
		write_reg(REG_ZOOM_LOWER, 16'd1024);
		write_reg(REG_ZOOM_UPPER, 16'd12000);
		write_reg(REG_ZOOM_MOTION, 16'd9000);
		// no idling here: the sender keeps valid high and the receiver keeps ready high
		idle_enabled = 1'b0;
		send_random(RANDOM_PER_PHASE);
		idle_enabled = 1'b1;

		// random mid-range setting, with a long receiver hold-off under traffic
		gyro_ch.valid <= 1'b0;
		wait_drained();
		write_reg(REG_ZOOM_DEFAULT, 16'($urandom_range(2048, 12000)));
		write_reg(REG_ZOOM_LOWER, 16'($urandom_range(0, 2048)));
		write_reg(REG_ZOOM_UPPER, 16'($urandom_range(12000, 65535)));
		write_reg(REG_ZOOM_MOTION, 16'($urandom_range(0, 20000)));
		write_reg(REG_SMOOTH_GAIN, 16'($urandom_range(1, 32768)));
		write_reg(REG_FULL_SCALE, 16'($urandom_range(200, 5000)));
		hold_request = 1'b1;
		send_random(RANDOM_PER_PHASE);

		gyro_ch.valid <= 1'b0;
		while (zoom_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d samples, %0d results, six register settings incl. crossed",
			samples_sent, results_seen);
		$display("limits, zero/over-range gain and full scale, and a long output stall.");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random back-pressure, checking and the stall watchdog
	// ------------------------------------------------------------------------
	initial zoom_ch.ready = 1'b0;

	always @(posedge clk) begin
		zoom_result_t want;
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			zoom_ch.ready <= 1'b0;
		end else begin
			zoom_ch.ready <= !(idle_enabled && $urandom_range(0, 99) < 8);
		end

		if (zoom_ch.valid && zoom_ch.ready) begin
			results_seen++;
			if (zoom_expect_q.size() == 0) begin
				$display("%0t: unexpected result now=%0d goal=%0d level=%0d", $time,
					zoom_ch.zoom_now, zoom_ch.zoom_goal, zoom_ch.motion_level);
				mismatches++;
			end else begin
				want = zoom_expect_q.pop_front();
				if (zoom_ch.zoom_now !== want.zoom_now) begin
					$display("%0t: zoom_now expected %0d got %0d", $time,
						want.zoom_now, zoom_ch.zoom_now);
					mismatches++;
				end
				if (zoom_ch.zoom_goal !== want.zoom_goal) begin
					$display("%0t: zoom_goal expected %0d got %0d", $time,
						want.zoom_goal, zoom_ch.zoom_goal);
					mismatches++;
				end
				if (zoom_ch.motion_level !== want.motion_level) begin
					$display("%0t: motion_level expected %0d got %0d", $time,
						want.motion_level, zoom_ch.motion_level);
					mismatches++;
				end
			end
		end

		// count cycles with no transfer on either channel
		if ((zoom_ch.valid && zoom_ch.ready) || (gyro_ch.valid && gyro_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
				quiet_cycles, zoom_expect_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

/* motion_envelope_zoom_smoother.f */
rtl/mezs_pkg.sv
rtl/mezs_in_if.sv
rtl/mezs_out_if.sv
rtl/motion_envelope_zoom_smoother.sv
tb/sv/testbench.sv
